// File: rtl/pgbd_pkg.sv
// Shared types, constants and register codes for the packed gray box downscaler.
package pgbd_pkg;

   localparam int MAX_DEST_WIDTH  = 1024;
   localparam int MAX_SRC_DIM     = 4096;
   localparam int SCALE_FRAC_BITS = 16;
   localparam int SCALE_ONE       = 1 << SCALE_FRAC_BITS;
   localparam int SUM_W           = 32;
   // One column can collect a full 4096 by 4096 frame, so the count needs 25 bits.
   localparam int CNT_W           = 25;

   typedef enum logic [2:0] {
      CSR_BPS        = 3'd0,
      CSR_SRC_WIDTH  = 3'd1,
      CSR_SRC_HEIGHT = 3'd2,
      CSR_DST_WIDTH  = 3'd3,
      CSR_DST_HEIGHT = 3'd4,
      CSR_SCALE_X    = 3'd5,
      CSR_SCALE_Y    = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROW,
      ST_FLAG,
      ST_READ,
      ST_UPD,
      ST_DIV,
      ST_FLUSH,
      ST_ADV,
      ST_LAST
   } state_type;

   typedef struct packed {
      logic clr_step;
      logic accept;
      logic row_mul;
      logic row_flag;
      logic rd;
      logic upd;
      logic div_start;
      logic load_pend;
      logic pend_clr;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic cfg_wr;
      logic clr_done;
      logic col_zero;
      logic emit;
      logic div_done;
      logic row_break;
      logic last_sample;
      logic pend_valid;
   } status_type;

endpackage

// File: rtl/pgbd_div.sv
// Restoring divider: one quotient bit per cycle, eight-bit quotient.
module pgbd_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [pgbd_pkg::SUM_W-1:0] dividend,
   input  logic [pgbd_pkg::CNT_W-1:0] divisor,
   output logic                       done,
   output logic [7:0]                 quotient
);
   import pgbd_pkg::*;

   logic [SUM_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] den_ff, den_in;
   logic [7:0]       q_ff, q_in;
   logic [2:0]       step_ff, step_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [SUM_W-1:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = SUM_W'({den_ff, 7'b0} >> (3'd7 - step_ff));
      if (start) begin
         rem_in  = dividend;
         den_in  = divisor;
         q_in    = '0;
         step_in = 3'd7;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in        = rem_ff - trial;
            q_in[step_ff] = 1'b1;
         end
         if (step_ff == 3'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// File: rtl/pgbd_ctrl.sv
// Controller state machine sequencing samples, divisions and result hand-off.
module pgbd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  pgbd_pkg::status_type status,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_last_of_item,
   output pgbd_pkg::cmd_type    cmd
);
   import pgbd_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in         = state_ff;
      cmd              = '0;
      req_ready        = 1'b0;
      rsp_valid        = 1'b0;
      rsp_last_of_item = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // An item is not taken in the cycle of a register write.
            req_ready = !status.cfg_wr;
            if (req_valid && !status.cfg_wr) begin
               cmd.accept = 1'b1;
               state_in   = status.col_zero ? ST_ROW : ST_READ;
            end
         end
         ST_ROW: begin
            cmd.row_mul = 1'b1;
            state_in    = ST_FLAG;
         end
         ST_FLAG: begin
            cmd.row_flag = 1'b1;
            state_in     = ST_READ;
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            cmd.upd = 1'b1;
            if (status.emit) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_ADV;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               if (status.pend_valid) begin
                  state_in = ST_FLUSH;
               end else begin
                  cmd.load_pend = 1'b1;
                  state_in      = ST_ADV;
               end
            end
         end
         ST_FLUSH: begin
            // An earlier result of this item goes out; the new one takes its place.
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.load_pend = 1'b1;
               state_in      = ST_ADV;
            end
         end
         ST_ADV: begin
            cmd.advance = 1'b1;
            if (status.row_break || status.last_sample) begin
               state_in = status.pend_valid ? ST_LAST : ST_IDLE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_LAST: begin
            rsp_valid        = 1'b1;
            rsp_last_of_item = 1'b1;
            if (rsp_ready) begin
               cmd.pend_clr = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
      // A register write restarts the frame from a fresh clearing pass.
      if (status.cfg_wr) begin
         state_in = ST_CLEAR;
      end
   end

endmodule

// File: rtl/pgbd_dp.sv
// Datapath: configuration, position counters, column memory and result register.
module pgbd_dp #(
   parameter int MAX_DEST_WIDTH = pgbd_pkg::MAX_DEST_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pgbd_pkg::cmd_type    cmd,
   output pgbd_pkg::status_type status,
   input  logic [7:0]           req_data_byte,
   input  logic                 csr_valid,
   input  logic [2:0]           csr_index,
   input  logic [16:0]          csr_data,
   output logic [7:0]           rsp_gray_value,
   output logic                 rsp_row_end,
   output logic                 rsp_frame_end
);
   import pgbd_pkg::*;

   localparam int AW    = (MAX_DEST_WIDTH > 1) ? $clog2(MAX_DEST_WIDTH) : 1;
   localparam int POS_W = 12 + 17;
   localparam int PRD_W = 30;

   // Configuration registers, stored as written.
   logic [3:0]  bps_ff;
   logic [12:0] src_w_ff, src_h_ff, dst_h_ff;
   logic [10:0] dst_w_ff;
   logic [16:0] sx_ff, sy_ff;

   logic cfg_wr;
   assign cfg_wr = csr_valid && (csr_index <= CSR_SCALE_Y);

   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff   <= 4'd8;
         src_w_ff <= 13'd1;
         src_h_ff <= 13'd1;
         dst_w_ff <= 11'd1;
         dst_h_ff <= 13'd1;
         sx_ff    <= 17'(SCALE_ONE);
         sy_ff    <= 17'(SCALE_ONE);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_BPS:        bps_ff   <= csr_data[3:0];
            CSR_SRC_WIDTH:  src_w_ff <= csr_data[12:0];
            CSR_SRC_HEIGHT: src_h_ff <= csr_data[12:0];
            CSR_DST_WIDTH:  dst_w_ff <= csr_data[10:0];
            CSR_DST_HEIGHT: dst_h_ff <= csr_data[12:0];
            CSR_SCALE_X:    sx_ff    <= csr_data;
            CSR_SCALE_Y:    sy_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // Effective settings after saturation.
   logic [3:0]  bps;
   logic [2:0]  spb_m1;
   logic [12:0] w, h, dh, dw_m1;
   logic [16:0] sxs, sys;

   always_comb begin
      case (bps_ff)
         4'd1:    begin bps = 4'd1; spb_m1 = 3'd7; end
         4'd2:    begin bps = 4'd2; spb_m1 = 3'd3; end
         4'd4:    begin bps = 4'd4; spb_m1 = 3'd1; end
         default: begin bps = 4'd8; spb_m1 = 3'd0; end
      endcase
      w  = (src_w_ff == '0) ? 13'd1 :
           (int'(src_w_ff) > MAX_SRC_DIM) ? 13'(MAX_SRC_DIM) : src_w_ff;
      h  = (src_h_ff == '0) ? 13'd1 :
           (int'(src_h_ff) > MAX_SRC_DIM) ? 13'(MAX_SRC_DIM) : src_h_ff;
      dh = (dst_h_ff == '0) ? 13'd1 :
           (int'(dst_h_ff) > MAX_SRC_DIM) ? 13'(MAX_SRC_DIM) : dst_h_ff;
      dw_m1 = (dst_w_ff == '0) ? 13'd0 :
              (int'(dst_w_ff) > MAX_DEST_WIDTH) ? 13'(MAX_DEST_WIDTH - 1) :
              13'(dst_w_ff - 11'd1);
      sxs = (sx_ff == '0) ? 17'd1 : (int'(sx_ff) > SCALE_ONE) ? 17'(SCALE_ONE) : sx_ff;
      sys = (sy_ff == '0) ? 17'd1 : (int'(sy_ff) > SCALE_ONE) ? 17'(SCALE_ONE) : sy_ff;
   end

   // Position state. pos_ff tracks source_column * scale_x.
   logic [11:0]      col_ff, row_ff;
   logic [12:0]      drow_ff;
   logic [POS_W-1:0] pos_ff, pos_nx;
   logic [2:0]       k_ff;
   logic [7:0]       byte_ff;
   logic             flag_ff;
   logic [PRD_W-1:0] prod_ff;
   logic [AW-1:0]    clr_addr_ff;

   logic        active, row_last;
   logic [12:0] colq, colq_nx, dx_w, dxn_w;
   logic [AW-1:0] dx;

   assign active   = drow_ff < dh;
   assign row_last = (13'(col_ff) + 13'd1) >= w;
   assign pos_nx   = pos_ff + POS_W'(sxs);
   assign colq     = pos_ff[SCALE_FRAC_BITS +: 13];
   assign colq_nx  = pos_nx[SCALE_FRAC_BITS +: 13];
   assign dx_w     = (colq > dw_m1) ? dw_m1 : colq;
   assign dxn_w    = (colq_nx > dw_m1) ? dw_m1 : colq_nx;
   assign dx       = dx_w[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         byte_ff <= req_data_byte;
      end else if (cmd.advance) begin
         byte_ff <= byte_ff << bps;
      end
      if (cmd.row_mul) begin
         prod_ff <= PRD_W'(13'(row_ff) + 13'd1) * PRD_W'(sys);
      end
      if (reset || cfg_wr) begin
         col_ff      <= '0;
         row_ff      <= '0;
         drow_ff     <= '0;
         pos_ff      <= '0;
         k_ff        <= '0;
         flag_ff     <= 1'b0;
         clr_addr_ff <= '0;
      end else begin
         if (cmd.clr_step) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
         end
         if (cmd.accept) begin
            k_ff <= '0;
         end
         if (cmd.row_flag) begin
            flag_ff <= ((13'(row_ff) + 13'd1) >= h) ||
                       (prod_ff >= (PRD_W'(drow_ff) + PRD_W'(1)) << SCALE_FRAC_BITS);
         end
         if (cmd.advance) begin
            k_ff <= k_ff + 3'd1;
            if (row_last) begin
               col_ff <= '0;
               pos_ff <= '0;
               if ((13'(row_ff) + 13'd1) >= h) begin
                  row_ff  <= '0;
                  drow_ff <= '0;
               end else begin
                  row_ff <= row_ff + 12'd1;
                  if (active && flag_ff) begin
                     drow_ff <= drow_ff + 13'd1;
                  end
               end
            end else begin
               col_ff <= col_ff + 12'd1;
               pos_ff <= pos_nx;
            end
         end
      end
   end

   // Sample expanded to eight bits by bit replication.
   logic [7:0] gray;
   always_comb begin
      case (bps)
         4'd1:    gray = {8{byte_ff[7]}};
         4'd2:    gray = {4{byte_ff[7:6]}};
         4'd4:    gray = {2{byte_ff[7:4]}};
         default: gray = byte_ff;
      endcase
   end

   // Column memory holding sum and count per destination column.
   logic [SUM_W+CNT_W-1:0] mem [MAX_DEST_WIDTH];
   logic [SUM_W-1:0]       rd_sum_ff, sum_new;
   logic [CNT_W-1:0]       rd_cnt_ff, cnt_new;
   logic                   emit;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [SUM_W+CNT_W-1:0] wr_data;

   assign sum_new = rd_sum_ff + SUM_W'(gray);
   assign cnt_new = rd_cnt_ff + CNT_W'(1);
   assign emit    = active && flag_ff && (row_last || (dxn_w != dx_w));

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = dx;
      wr_data = {sum_new, cnt_new};
      if (cmd.clr_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else if (cmd.upd && active) begin
         wr_en = 1'b1;
         // A column that is read out starts its next group from zero.
         if (emit) begin
            wr_data = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd) begin
         {rd_sum_ff, rd_cnt_ff} <= mem[dx];
      end
   end

   // Division and the pending result register.
   logic       div_done;
   logic [7:0] quot;
   logic       emit_re_ff, emit_fe_ff;
   logic [7:0] pend_gray_ff;
   logic       pend_re_ff, pend_fe_ff, pend_valid_ff;

   pgbd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_new),
      .divisor  (cnt_new),
      .done     (div_done),
      .quotient (quot)
   );

   always_ff @(posedge clock) begin
      if (cmd.upd) begin
         emit_re_ff <= row_last;
         emit_fe_ff <= row_last &&
                       (((drow_ff + 13'd1) >= dh) || ((13'(row_ff) + 13'd1) >= h));
      end
      if (cmd.load_pend) begin
         pend_gray_ff <= quot;
         pend_re_ff   <= emit_re_ff;
         pend_fe_ff   <= emit_fe_ff;
      end
      if (reset || cfg_wr) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.load_pend) begin
         pend_valid_ff <= 1'b1;
      end else if (cmd.pend_clr) begin
         pend_valid_ff <= 1'b0;
      end
   end

   assign rsp_gray_value = pend_gray_ff;
   assign rsp_row_end    = pend_re_ff;
   assign rsp_frame_end  = pend_fe_ff;

   always_comb begin
      status.cfg_wr      = cfg_wr;
      status.clr_done    = clr_addr_ff == AW'(MAX_DEST_WIDTH - 1);
      status.col_zero    = col_ff == '0;
      status.emit        = emit;
      status.div_done    = div_done;
      status.row_break   = row_last;
      status.last_sample = k_ff == spb_m1;
      status.pend_valid  = pend_valid_ff;
   end

endmodule

// File: rtl/packed_gray_box_downscaler_top.sv
// Top level of the packed gray box downscaler: controller plus datapath.
// An item is accepted in ST_IDLE; at a row start ST_ROW and ST_FLAG do the row-group
// multiply and compare. Each of its 1 to 8 samples passes ST_READ, ST_UPD and ST_ADV;
// one that completes a pixel waits in ST_DIV and, with a result pending, in ST_FLUSH,
// where output stalls can hold it. After reset and every register write a clearing pass
// zeroes the column memory; no item is accepted until it ends. Reset is synchronous.
module packed_gray_box_downscaler_top #(
   parameter int MAX_DEST_WIDTH = pgbd_pkg::MAX_DEST_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_gray_value,
   output logic        rsp_row_end,
   output logic        rsp_frame_end,
   output logic        rsp_last_of_item,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_data
);
   import pgbd_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   pgbd_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .status           (status),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_last_of_item (rsp_last_of_item),
      .cmd              (cmd)
   );

   pgbd_dp #(
      .MAX_DEST_WIDTH (MAX_DEST_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_data_byte  (req_data_byte),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_gray_value (rsp_gray_value),
      .rsp_row_end    (rsp_row_end),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule

// File: test/tb_packed_gray_box_downscaler_top.sv
// Self-checking testbench for the packed gray box downscaler: random handshakes, own predictor.
`timescale 1ns / 1ps
module tb_packed_gray_box_downscaler_top;
   import pgbd_pkg::*;

   typedef struct packed {
      logic [7:0] gray;
      logic       row_end;
      logic       frame_end;
      logic       last_of_item;
   } pixel_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_gray_value;
   logic        rsp_row_end;
   logic        rsp_frame_end;
   logic        rsp_last_of_item;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [16:0] csr_data;

   // Configuration and position as the predictor sees them.
   logic [3:0]  cfg_bps;
   logic [12:0] cfg_src_w, cfg_src_h, cfg_dst_h;
   logic [10:0] cfg_dst_w;
   logic [16:0] cfg_sx, cfg_sy;
   logic [31:0] col_sum [MAX_DEST_WIDTH];
   logic [31:0] col_cnt [MAX_DEST_WIDTH];
   int unsigned src_col, src_row, dst_row;
   bit          last_row_of_group;

   pixel_type   pending_pixels[$];
   int          error_count;
   int          pixels_seen;
   int          bytes_sent;
   int          idle_cycles;
   int          rsp_wait;
   bit          rsp_stall_off;

   packed_gray_box_downscaler_top DUT (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int unsigned dest_column(int unsigned sx, int unsigned sxs,
                                               int unsigned dw);
      longint unsigned c;
      c = (longint'(sx) * sxs) >> SCALE_FRAC_BITS;
      if (c > dw - 1) c = dw - 1;
      return int'(c);
   endfunction

   function automatic void restart_frame();
      for (int i = 0; i < MAX_DEST_WIDTH; i++) begin
         col_sum[i] = '0;
         col_cnt[i] = '0;
      end
      src_col = 0;
      src_row = 0;
      dst_row = 0;
      last_row_of_group = 1'b0;
   endfunction

   // Works out the pixels one source byte releases and queues them.
   function automatic void predict_pixels(logic [7:0] data);
      int unsigned bps, spb, vmax, w, h, dw, dh, sxs, sys, v, g, dx, first;
      bit active, row_last, fe;
      pixel_type px;
      bps = (cfg_bps == 1 || cfg_bps == 2 || cfg_bps == 4) ? cfg_bps : 8;
      spb = 8 / bps;
      vmax = (1 << bps) - 1;
      w = clamp(cfg_src_w, 1, MAX_SRC_DIM);
      h = clamp(cfg_src_h, 1, MAX_SRC_DIM);
      dw = clamp(cfg_dst_w, 1, MAX_DEST_WIDTH);
      dh = clamp(cfg_dst_h, 1, MAX_SRC_DIM);
      sxs = clamp(cfg_sx, 1, SCALE_ONE);
      sys = clamp(cfg_sy, 1, SCALE_ONE);
      first = pending_pixels.size();
      for (int k = 0; k < spb; k++) begin
         active = dst_row < dh;
         if (src_col == 0)
            last_row_of_group = (src_row + 1 >= h) ||
               (longint'(src_row + 1) * sys >= (longint'(dst_row + 1) << SCALE_FRAC_BITS));
         v = (data >> (8 - bps * (k + 1))) & vmax;
         g = (255 * v) / vmax;
         if (active) begin
            dx = dest_column(src_col, sxs, dw);
            col_sum[dx] += g;
            col_cnt[dx] += 1;
            if (last_row_of_group) begin
               row_last = src_col + 1 >= w;
               if (row_last || dest_column(src_col + 1, sxs, dw) != dx) begin
                  fe = row_last && (dst_row + 1 >= dh || src_row + 1 >= h);
                  px.gray = col_cnt[dx] != 0 ? 8'(col_sum[dx] / col_cnt[dx]) : 8'd0;
                  px.row_end = row_last;
                  px.frame_end = fe;
                  px.last_of_item = 1'b0;
                  pending_pixels.push_back(px);
                  col_sum[dx] = '0;
                  col_cnt[dx] = '0;
               end
            end
         end
         src_col++;
         if (src_col >= w) begin
            src_col = 0;
            if (active && last_row_of_group) dst_row++;
            src_row++;
            if (src_row >= h) begin
               src_row = 0;
               dst_row = 0;
            end
            break;
         end
      end
      if (pending_pixels.size() > first)
         pending_pixels[pending_pixels.size() - 1].last_of_item = 1'b1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            pixel_type want;
            pixel_type got;
            got = '{rsp_gray_value, rsp_row_end, rsp_frame_end, rsp_last_of_item};
            pixels_seen++;
            if (pending_pixels.size() == 0) begin
               $display("%0t: unexpected pixel %p", $time, got);
               error_count++;
            end else begin
               want = pending_pixels.pop_front();
               if (got.gray !== want.gray) begin
                  $display("%0t: gray expected %0d actual %0d", $time, want.gray, got.gray);
                  error_count++;
               end
               if (got.row_end !== want.row_end) begin
                  $display("%0t: row_end expected %0d actual %0d", $time, want.row_end,
                           got.row_end);
                  error_count++;
               end
               if (got.frame_end !== want.frame_end) begin
                  $display("%0t: frame_end expected %0d actual %0d", $time, want.frame_end,
                           got.frame_end);
                  error_count++;
               end
               if (got.last_of_item !== want.last_of_item) begin
                  $display("%0t: last_of_item expected %0d actual %0d", $time,
                           want.last_of_item, got.last_of_item);
                  error_count++;
               end
            end
            // Each result draws how many cycles the receiver waits before the next one.
            rsp_wait = rsp_stall_off ? 0 : int'($urandom_range(0, 19));
            rsp_ready <= (rsp_wait == 0);
         end else if (!rsp_ready) begin
            if (rsp_wait > 0) rsp_wait--;
            rsp_ready <= (rsp_wait == 0);
         end
      end
   end

   // Watchdog: cycles in a row with no handshake on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic write_register(csr_index_type idx, logic [16:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      case (idx)
         CSR_BPS:        cfg_bps = value[3:0];
         CSR_SRC_WIDTH:  cfg_src_w = value[12:0];
         CSR_SRC_HEIGHT: cfg_src_h = value[12:0];
         CSR_DST_WIDTH:  cfg_dst_w = value[10:0];
         CSR_DST_HEIGHT: cfg_dst_h = value[12:0];
         CSR_SCALE_X:    cfg_sx = value;
         default:        cfg_sy = value;
      endcase
      restart_frame();
   endtask

   task automatic send_byte(logic [7:0] data, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 19);
      repeat (gap) @(posedge clock);
      @(posedge clock);
      req_valid <= 1'b1;
      req_data_byte <= data;
      do @(posedge clock); while (!(req_valid && req_ready));
      predict_pixels(data);
      bytes_sent++;
      req_valid <= 1'b0;
   endtask

   task automatic drain_pixels();
      while (pending_pixels.size() != 0) @(posedge clock);
      // A byte may still be in flight without producing a pixel.
      repeat (300) @(posedge clock);
   endtask

   task automatic setup(int bps, int sw, int sh, int dw, int dh, int sx, int sy);
      drain_pixels();
      write_register(CSR_BPS, 17'(bps));
      write_register(CSR_SRC_WIDTH, 17'(sw));
      write_register(CSR_SRC_HEIGHT, 17'(sh));
      write_register(CSR_DST_WIDTH, 17'(dw));
      write_register(CSR_DST_HEIGHT, 17'(dh));
      write_register(CSR_SCALE_X, 17'(sx));
      write_register(CSR_SCALE_Y, 17'(sy));
   endtask

   // Reset values: one 8-bit sample per frame, full scale.
   task automatic test_reset_defaults();
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h5a, 1'b1);
   endtask

   task automatic test_directed_depths();
      // One bit per sample, half scale, padding at the end of each row.
      setup(1, 11, 3, 5, 1, 32768, 32768);
      send_byte(8'hff, 1'b0);
      send_byte(8'ha0, 1'b0);
      send_byte(8'h0f, 1'b0);
      send_byte(8'he0, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'h20, 1'b0);
      // Two bits per sample, dst_width beyond what the mapping reaches.
      setup(2, 6, 2, 1000, 2, 21845, 65536);
      send_byte(8'hc6, 1'b0);
      send_byte(8'h90, 1'b0);
      send_byte(8'h1b, 1'b0);
      send_byte(8'hf0, 1'b0);
      // Four bits, out-of-range depth and sizes and scales of zero and above one.
      setup(4, 3, 2, 1, 1, 0, 0);
      send_byte(8'hf0, 1'b0);
      send_byte(8'h71, 1'b0);
      send_byte(8'h8e, 1'b0);
      send_byte(8'h3c, 1'b0);
      setup(15, 8191, 0, 2047, 8191, 131071, 131071);
      send_byte(8'h80, 1'b0);
      send_byte(8'h7f, 1'b0);
      setup(3, 0, 8191, 0, 0, 65536, 1);
      send_byte(8'h01, 1'b0);
      send_byte(8'hfe, 1'b0);
   endtask

   task automatic run_random_frames(int byte_budget);
      int bps_choice[4] = '{1, 2, 4, 8};
      int bps, sw, sh, dw, dh, sx, sy, row_bytes, n;
      while (byte_budget > 0) begin
         bps = bps_choice[$urandom_range(0, 3)];
         if ($urandom_range(0, 9) == 0) bps = $urandom_range(0, 15);
         sw = $urandom_range(1, 24);
         sh = $urandom_range(1, 8);
         sx = $urandom_range(0, 3) == 0 ? 65536 : $urandom_range(8000, 65536);
         sy = $urandom_range(0, 3) == 0 ? 65536 : $urandom_range(8000, 65536);
         dw = int'((longint'(sw) * sx) >> 16);
         dh = int'((longint'(sh) * sy) >> 16);
         if ($urandom_range(0, 4) == 0) dw = $urandom_range(0, 30);
         if ($urandom_range(0, 4) == 0) dh = $urandom_range(0, 10);
         if (dw == 0) dw = 1;
         setup(bps, sw, sh, dw, dh, sx, sy);
         bps = (bps == 1 || bps == 2 || bps == 4) ? bps : 8;
         row_bytes = (sw + 8 / bps - 1) / (8 / bps);
         // One or two whole frames, often followed by up to two bytes of a further frame.
         n = row_bytes * sh * $urandom_range(1, 2) + $urandom_range(0, 2);
         for (int i = 0; i < n && byte_budget > 0; i++) begin
            send_byte(8'($urandom()), $urandom_range(0, 3) == 0);
            byte_budget--;
         end
         rsp_stall_off = $urandom_range(0, 3) == 0;
      end
      rsp_stall_off = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = '0;
      csr_valid = 1'b0;
      csr_index = CSR_BPS;
      csr_data = '0;
      error_count = 0;
      pixels_seen = 0;
      bytes_sent = 0;
      rsp_stall_off = 1'b0;
      cfg_bps = 4'd8;
      cfg_src_w = 13'd1;
      cfg_src_h = 13'd1;
      cfg_dst_w = 11'd1;
      cfg_dst_h = 13'd1;
      cfg_sx = 17'd65536;
      cfg_sy = 17'd65536;
      restart_frame();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_depths();
      run_random_frames(440);
      drain_pixels();
      $display("Sent %0d source bytes and checked %0d pixels", bytes_sent, pixels_seen);
      $display("over all sample depths, clamped sizes and scales, and frame wraps.");
      if (error_count == 0 && pending_pixels.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
